// ===== hdl/hex_spiral_walker_macros.svh =====
// ----------------------------------------------------------------------------
// hex spiral walker assertion macros
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef HEX_SPIRAL_WALKER_MACROS_SVH
`define HEX_SPIRAL_WALKER_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, disabled during reset
`define HSW_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hsw assertion failed");

// next-cycle implication, disabled during reset
`define HSW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hsw assertion failed");

`else

`define HSW_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define HSW_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/hsw_pkg.sv =====
// ----------------------------------------------------------------------------
// hsw_pkg
// Shared types and constants of the hex spiral walker.
// ----------------------------------------------------------------------------
package hsw_pkg;

    // default signed width of row and column
    localparam int POS_BITS_DEF = 10;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WRAP_DISABLED = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LAST_COL      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LAST_ROW      = 2'd2;
    localparam int CFG_DATA_BITS = 8;

    // configuration reset values
    localparam logic [7:0] LAST_COL_RESET = 8'h6B;
    localparam logic [7:0] LAST_ROW_RESET = 8'h3B;

    // request types
    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    // hex directions, odd rows shifted half a hex east
    localparam logic [2:0] DIR_NE = 3'd0;
    localparam logic [2:0] DIR_E  = 3'd1;
    localparam logic [2:0] DIR_SE = 3'd2;
    localparam logic [2:0] DIR_SW = 3'd3;
    localparam logic [2:0] DIR_W  = 3'd4;
    localparam logic [2:0] DIR_NW = 3'd5;

    // ring counter ceiling
    localparam logic [7:0] RING_MAX = 8'hFF;

    // tile index width and the off-grid code
    localparam int TILE_BITS = 17;
    localparam logic [TILE_BITS-1:0] TILE_NONE = {TILE_BITS{1'b1}};

    // grid configuration
    typedef struct packed {
        logic       wrap_disabled;
        logic [7:0] last_col;
        logic [7:0] last_row;
    } cfg_t;

endpackage

// ===== hdl/hsw_hex_move.sv =====
// ----------------------------------------------------------------------------
// hsw_hex_move
// One hex step on the offset-row grid with wrap and saturation.
// ----------------------------------------------------------------------------
module hsw_hex_move #(
    parameter int POS_BITS = hsw_pkg::POS_BITS_DEF
) (
    input  hsw_pkg::cfg_t               cfg,
    input  logic [2:0]                  dir,
    input  logic signed [POS_BITS-1:0]  row_in,
    input  logic signed [POS_BITS-1:0]  col_in,
    output logic signed [POS_BITS-1:0]  row_out,
    output logic signed [POS_BITS-1:0]  col_out
);
    import hsw_pkg::*;

    localparam int W = POS_BITS + 2;
    localparam logic signed [W-1:0] POS_MAX = {3'b000, {(POS_BITS-1){1'b1}}};
    localparam logic signed [W-1:0] POS_MIN = {3'b111, {(POS_BITS-1){1'b0}}};
    localparam logic signed [W-1:0] ONE     = {{(W-1){1'b0}}, 1'b1};
    localparam logic signed [W-1:0] ZERO    = '0;

    function automatic logic signed [POS_BITS-1:0] sat(input logic signed [W-1:0] v);
        logic signed [POS_BITS-1:0] r;
        if (v > POS_MAX) begin
            r = POS_MAX[POS_BITS-1:0];
        end else if (v < POS_MIN) begin
            r = POS_MIN[POS_BITS-1:0];
        end else begin
            r = v[POS_BITS-1:0];
        end
        return r;
    endfunction

    logic signed [W-1:0] col_w;
    logic signed [W-1:0] row_w;
    logic signed [W-1:0] lc_w;
    logic signed [W-1:0] cand;
    logic                odd;
    logic                go_west;
    logic                go_east;
    logic                row_move_en;

    // column move with wrap or escape, then row move
    always_comb begin
        col_w       = {{2{col_in[POS_BITS-1]}}, col_in};
        row_w       = {{2{row_in[POS_BITS-1]}}, row_in};
        lc_w        = {{(W-8){1'b0}}, cfg.last_col};
        odd         = row_in[0];
        go_west     = (dir == DIR_W) || ((dir > DIR_SE) && !odd);
        go_east     = (dir == DIR_E) || ((dir < DIR_SW) && odd);
        cand        = col_w;
        row_move_en = 1'b1;
        if (go_west) begin
            cand = col_w - ONE;
            if (cand[W-1]) begin
                if (cfg.wrap_disabled) begin
                    row_move_en = 1'b0;
                end else begin
                    cand = lc_w;
                end
            end
        end else if (go_east) begin
            cand = col_w + ONE;
            if (cand > lc_w) begin
                if (cfg.wrap_disabled) begin
                    row_move_en = 1'b0;
                end else begin
                    cand = ZERO;
                end
            end
        end
        col_out = sat(cand);

        row_out = row_in;
        if (row_move_en && ((dir == DIR_NE) || (dir == DIR_NW))) begin
            row_out = sat(row_w - ONE);
        end else if (row_move_en && ((dir == DIR_SE) || (dir == DIR_SW))) begin
            row_out = sat(row_w + ONE);
        end
    end

endmodule

// ===== hdl/hsw_step.sv =====
// ----------------------------------------------------------------------------
// hsw_step
// Next walk state for one item: load, or advance with turn and ring growth.
// ----------------------------------------------------------------------------
module hsw_step #(
    parameter int POS_BITS = hsw_pkg::POS_BITS_DEF
) (
    input  hsw_pkg::cfg_t               cfg,
    input  logic                        req_type,
    input  logic signed [POS_BITS-1:0]  load_row,
    input  logic signed [POS_BITS-1:0]  load_col,
    input  logic [7:0]                  load_ring,
    input  logic [2:0]                  load_direction,
    input  logic [7:0]                  load_step,
    input  logic signed [POS_BITS-1:0]  row,
    input  logic signed [POS_BITS-1:0]  col,
    input  logic [7:0]                  ring,
    input  logic [2:0]                  direction,
    input  logic [7:0]                  step,
    output logic signed [POS_BITS-1:0]  row_next,
    output logic signed [POS_BITS-1:0]  col_next,
    output logic [7:0]                  ring_next,
    output logic [2:0]                  direction_next,
    output logic [7:0]                  step_next
);
    import hsw_pkg::*;

    logic [8:0]                 step_inc;
    logic [3:0]                 dir_inc;
    logic                       turn;
    logic                       new_ring;
    logic [7:0]                 adv_ring;
    logic [2:0]                 adv_dir;
    logic [7:0]                 adv_step;
    logic signed [POS_BITS-1:0] west_row;
    logic signed [POS_BITS-1:0] west_col;
    logic signed [POS_BITS-1:0] mid_row;
    logic signed [POS_BITS-1:0] mid_col;
    logic signed [POS_BITS-1:0] adv_row;
    logic signed [POS_BITS-1:0] adv_col;

    // step count, turn at the end of a side, next ring after the last side
    always_comb begin
        step_inc = {1'b0, step} + 9'd1;
        dir_inc  = {1'b0, direction} + 4'd1;
        turn     = ({1'b0, ring} <= step_inc);
        new_ring = turn && (dir_inc > {1'b0, DIR_NW});
        adv_ring = ring;
        adv_dir  = direction;
        adv_step = step_inc[7:0];
        if (turn) begin
            adv_step = '0;
            adv_dir  = dir_inc[2:0];
            if (new_ring) begin
                adv_dir = DIR_NE;
                if (ring != RING_MAX) begin
                    adv_ring = ring + 8'd1;
                end
            end
        end
    end

    // extra west step that opens a new ring
    hsw_hex_move #(.POS_BITS(POS_BITS)) u_west_move (
        .cfg     (cfg),
        .dir     (DIR_W),
        .row_in  (row),
        .col_in  (col),
        .row_out (west_row),
        .col_out (west_col)
    );

    assign mid_row = new_ring ? west_row : row;
    assign mid_col = new_ring ? west_col : col;

    // regular step in the current direction
    hsw_hex_move #(.POS_BITS(POS_BITS)) u_dir_move (
        .cfg     (cfg),
        .dir     (adv_dir),
        .row_in  (mid_row),
        .col_in  (mid_col),
        .row_out (adv_row),
        .col_out (adv_col)
    );

    // load takes the given state as is
    always_comb begin
        if (req_type == REQ_LOAD) begin
            row_next       = load_row;
            col_next       = load_col;
            ring_next      = load_ring;
            direction_next = load_direction;
            step_next      = load_step;
        end else begin
            row_next       = adv_row;
            col_next       = adv_col;
            ring_next      = adv_ring;
            direction_next = adv_dir;
            step_next      = adv_step;
        end
    end

endmodule

// ===== hdl/hsw_tile.sv =====
// ----------------------------------------------------------------------------
// hsw_tile
// Tile index of a grid position, or the off-grid code.
// ----------------------------------------------------------------------------
module hsw_tile #(
    parameter int POS_BITS = hsw_pkg::POS_BITS_DEF
) (
    input  hsw_pkg::cfg_t                        cfg,
    input  logic signed [POS_BITS-1:0]           row,
    input  logic signed [POS_BITS-1:0]           col,
    output logic [hsw_pkg::TILE_BITS-1:0]        tile_index
);
    import hsw_pkg::*;

    logic                 in_grid;
    logic [TILE_BITS-1:0] width;
    logic [TILE_BITS-1:0] product;

    // bounds check against the grid
    always_comb begin
        in_grid = !row[POS_BITS-1] && !col[POS_BITS-1]
            && ({1'b0, row} <= {{(POS_BITS-7){1'b0}}, cfg.last_row})
            && ({1'b0, col} <= {{(POS_BITS-7){1'b0}}, cfg.last_col});
    end

    // row times grid width plus column, row and column fit in 8 bits here
    always_comb begin
        width   = {{(TILE_BITS-8){1'b0}}, cfg.last_col} + {{(TILE_BITS-1){1'b0}}, 1'b1};
        product = {{(TILE_BITS-8){1'b0}}, row[7:0]} * width;
        if (in_grid) begin
            tile_index = product + {{(TILE_BITS-8){1'b0}}, col[7:0]};
        end else begin
            tile_index = TILE_NONE;
        end
    end

endmodule

// ===== hdl/hex_spiral_walker.sv =====
// ----------------------------------------------------------------------------
// hex_spiral_walker
// Outward hex spiral walk on an offset-row grid, one item per clock unless stalled.
// ----------------------------------------------------------------------------
// The walker takes one item every clock while the output is not stalled and
// returns one result per item. The first stage computes the next walk state
// (turn, ring growth, the ring-opening west step and the directional step)
// from the walk state registers and writes them back, so consecutive advance
// items chain through that register update. The second stage forms the tile
// index with a small multiply into the output register. Both stages hold under
// backpressure; with both stages full, m_ready low drops s_ready in the same
// cycle, while a stall with only the output stage full is absorbed by stage one.
module hex_spiral_walker #(
    parameter int POS_BITS = hsw_pkg::POS_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [hsw_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [hsw_pkg::CFG_DATA_BITS-1:0]     cfg_wr_data,
    // input channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_req_type,
    input  logic signed [POS_BITS-1:0]            s_load_row,
    input  logic signed [POS_BITS-1:0]            s_load_col,
    input  logic [7:0]                            s_load_ring,
    input  logic [2:0]                            s_load_direction,
    input  logic [7:0]                            s_load_step,
    // result channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [POS_BITS-1:0]            m_cur_row,
    output logic signed [POS_BITS-1:0]            m_cur_col,
    output logic [7:0]                            m_cur_ring,
    output logic [2:0]                            m_cur_direction,
    output logic [7:0]                            m_cur_step,
    output logic signed [hsw_pkg::TILE_BITS-1:0]  m_tile_index
);
    import hsw_pkg::*;

`include "hex_spiral_walker_macros.svh"

    cfg_t                       cfg_reg;

    logic signed [POS_BITS-1:0] walk_row_reg;
    logic signed [POS_BITS-1:0] walk_col_reg;
    logic [7:0]                 walk_ring_reg;
    logic [2:0]                 walk_direction_reg;
    logic [7:0]                 walk_step_reg;
    logic                       s1_valid_reg;

    logic signed [POS_BITS-1:0] walk_row_next;
    logic signed [POS_BITS-1:0] walk_col_next;
    logic [7:0]                 walk_ring_next;
    logic [2:0]                 walk_direction_next;
    logic [7:0]                 walk_step_next;

    logic signed [POS_BITS-1:0] m_row_reg;
    logic signed [POS_BITS-1:0] m_col_reg;
    logic [7:0]                 m_ring_reg;
    logic [2:0]                 m_direction_reg;
    logic [7:0]                 m_step_reg;
    logic [TILE_BITS-1:0]       m_tile_reg;
    logic                       m_valid_reg;

    logic [TILE_BITS-1:0]       tile_next;
    logic                       s_xfer;
    logic                       s1_adv;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wrap_disabled <= 1'b0;
            cfg_reg.last_col      <= LAST_COL_RESET;
            cfg_reg.last_row      <= LAST_ROW_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_WRAP_DISABLED: cfg_reg.wrap_disabled <= cfg_wr_data[0];
                CFG_LAST_COL:      cfg_reg.last_col      <= cfg_wr_data[7:0];
                CFG_LAST_ROW:      cfg_reg.last_row      <= cfg_wr_data[7:0];
                default:           ;
            endcase
        end
    end

    // pipeline handshake
    assign s1_adv  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_adv;
    assign s_xfer  = s_valid && s_ready;

    // next walk state
    hsw_step #(.POS_BITS(POS_BITS)) u_step (
        .cfg            (cfg_reg),
        .req_type       (s_req_type),
        .load_row       (s_load_row),
        .load_col       (s_load_col),
        .load_ring      (s_load_ring),
        .load_direction (s_load_direction),
        .load_step      (s_load_step),
        .row            (walk_row_reg),
        .col            (walk_col_reg),
        .ring           (walk_ring_reg),
        .direction      (walk_direction_reg),
        .step           (walk_step_reg),
        .row_next       (walk_row_next),
        .col_next       (walk_col_next),
        .ring_next      (walk_ring_next),
        .direction_next (walk_direction_next),
        .step_next      (walk_step_next)
    );

    // stage one: walk state doubles as the stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_row_reg       <= '0;
            walk_col_reg       <= '0;
            walk_ring_reg      <= '0;
            walk_direction_reg <= '0;
            walk_step_reg      <= '0;
            s1_valid_reg       <= 1'b0;
        end else begin
            if (s_xfer) begin
                walk_row_reg       <= walk_row_next;
                walk_col_reg       <= walk_col_next;
                walk_ring_reg      <= walk_ring_next;
                walk_direction_reg <= walk_direction_next;
                walk_step_reg      <= walk_step_next;
                s1_valid_reg       <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg       <= 1'b0;
            end
        end
    end

    // tile index of the stage one position
    hsw_tile #(.POS_BITS(POS_BITS)) u_tile (
        .cfg        (cfg_reg),
        .row        (walk_row_reg),
        .col        (walk_col_reg),
        .tile_index (tile_next)
    );

    // stage two: result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_row_reg       <= walk_row_reg;
            m_col_reg       <= walk_col_reg;
            m_ring_reg      <= walk_ring_reg;
            m_direction_reg <= walk_direction_reg;
            m_step_reg      <= walk_step_reg;
            m_tile_reg      <= tile_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_cur_row       = m_row_reg;
    assign m_cur_col       = m_col_reg;
    assign m_cur_ring      = m_ring_reg;
    assign m_cur_direction = m_direction_reg;
    assign m_cur_step      = m_step_reg;
    assign m_tile_index    = m_tile_reg;

    // checks
    `HSW_ASSERT_SAME(a_stall_blocks_input, aclk, aresetn,
        s1_valid_reg && m_valid_reg && !m_ready, !s_ready)
    `HSW_ASSERT_NEXT(a_stage_moves_to_output, aclk, aresetn, s1_adv, m_valid_reg)
    `HSW_ASSERT_NEXT(a_load_takes_row, aclk, aresetn,
        s_xfer && (s_req_type == REQ_LOAD), walk_row_reg == $past(s_load_row))
    `HSW_ASSERT_NEXT(a_advance_step_count, aclk, aresetn,
        s_xfer && (s_req_type == REQ_ADVANCE),
        (walk_step_reg == 8'd0) || (walk_step_reg == $past(walk_step_reg) + 8'd1))
    `HSW_ASSERT_SAME(a_tile_range, aclk, aresetn,
        m_valid_reg, (m_tile_reg == TILE_NONE) || !m_tile_reg[TILE_BITS-1])

endmodule
